// ===== design/assert_macros.svh =====
// Assertion macros shared by the trie engine RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/lte_pkg.sv =====
// Shared types and constants for the lowercase trie engine.
// Used by the controller, the datapath and the top level; no dependencies.
package lte_pkg;

  // Beat widths on the stream ports
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  // Code of the first letter of the alphabet
  localparam logic [7:0] FIRST_LETTER = 8'd97;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_PREFIX = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POOL_FULL = 2'd1,
    ST_BAD_CHAR  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_FLAG
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;    // latch the incoming beat, issue child read
    logic clear;   // write one zero entry of the clearing pass
    logic walk;    // apply the child lookup of the latched character
    logic finish;  // produce the answer and return to the root
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;   // clearing pass is on its last entry
    logic pend_full;  // an answer waits behind the output register
    logic ends;       // latched item ends the word
    logic search;     // latched item is a whole-word search
  } dp_status_t;

  // Operation code three behaves as a prefix test
  function automatic op_t decode_op(input logic [1:0] raw);
    op_t op;
    op = raw[1] ? OP_PREFIX : op_t'(raw);
    return op;
  endfunction

endpackage

// ===== design/lte_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lte_ctrl.sv =====
// Sequencing state machine of the trie engine.
// Depends on lte_pkg for state, command and status types.
module lte_ctrl import lte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t stat,
  output logic       in_ready,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && !stat.pend_full) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (stat.ends && stat.search) begin
          state_next = S_FLAG;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FLAG: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
      end
      S_IDLE: begin
        in_ready = !stat.pend_full;
        cmd.take = in_valid && !stat.pend_full;
      end
      S_LOOKUP: begin
        cmd.walk   = 1'b1;
        cmd.finish = stat.ends && !stat.search;
      end
      S_FLAG: begin
        cmd.finish = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== design/lte_dp.sv =====
// Datapath of the trie engine: child table, word-end flags, walk registers,
// output register and skid slot. Depends on lte_pkg and lte_ram.
module lte_dp import lte_pkg::*; #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            stat,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  input  logic                  s_tuser,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int DEPTH  = NODE_COUNT * ALPHABET_SIZE;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [8:0]        ALPHA_LIM = 9'(ALPHABET_SIZE);
  localparam logic [ADDR_W-1:0] ALPHA_A   = ADDR_W'(ALPHABET_SIZE);
  localparam logic [ADDR_W-1:0] NODE_LIM  = ADDR_W'(NODE_COUNT);
  localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(DEPTH - 1);
  localparam logic [NODE_W:0]   POOL_N    = (NODE_W + 1)'(NODE_COUNT);

  // Incoming beat
  logic [1:0]        in_op_raw;
  logic [7:0]        in_letter;
  logic [7:0]        in_idx;
  logic              in_bad;
  logic [ADDR_W-1:0] in_slot;

  // Latched item
  op_t               it_op;
  logic              it_bad;
  logic              it_empty;
  logic              it_ends;
  logic [ADDR_W-1:0] it_slot;

  // Walk state
  logic [NODE_W-1:0] cursor;
  logic [NODE_W:0]   nodes_used;
  logic              walk_failed;
  status_t           error_code;
  logic              any_word;
  logic [ADDR_W-1:0] clr_addr;

  logic [NODE_W-1:0] cursor_next;
  logic [NODE_W:0]   nodes_used_next;
  logic              walk_failed_next;
  status_t           error_code_next;
  logic              any_word_next;
  logic              alloc;

  // Memories
  logic              child_we;
  logic [ADDR_W-1:0] child_waddr;
  logic [NODE_W-1:0] child_wdata;
  logic [NODE_W-1:0] child_rdata;
  logic              flag_we;
  logic [NODE_W-1:0] flag_waddr;
  logic [0:0]        flag_wdata;
  logic [0:0]        flag_rdata;

  // Answer and output stage
  logic    mark;
  logic    res_found;
  logic    out_free;
  logic    out_found;
  status_t out_status;
  logic    pend_valid;
  logic    pend_found;
  status_t pend_status;

  // Unpack the beat and form the child slot address
  assign in_op_raw = s_tdata[1:0];
  assign in_letter = s_tdata[9:2];
  assign in_idx    = in_letter - FIRST_LETTER;
  assign in_bad    = (in_letter < FIRST_LETTER) || ({1'b0, in_idx} >= ALPHA_LIM);
  assign in_slot   = ADDR_W'(cursor) * ALPHA_A + ADDR_W'(in_idx);

  // Latch the item on accept
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      it_op    <= decode_op(in_op_raw);
      it_bad   <= in_bad;
      it_empty <= s_tuser;
      it_ends  <= s_tuser || s_tlast;
      it_slot  <= in_slot;
    end
  end

  // Walk one character against the child entry just read
  always_comb begin
    cursor_next      = cursor;
    nodes_used_next  = nodes_used;
    walk_failed_next = walk_failed;
    error_code_next  = error_code;
    any_word_next    = any_word;
    alloc            = 1'b0;
    if (cmd.walk && !it_empty && !walk_failed) begin
      if (it_bad) begin
        walk_failed_next = 1'b1;
        error_code_next  = ST_BAD_CHAR;
      end else begin
        if (it_op == OP_INSERT) begin
          any_word_next = 1'b1;
        end
        if (child_rdata == '0) begin
          if (it_op != OP_INSERT) begin
            walk_failed_next = 1'b1;
          end else if (nodes_used >= POOL_N) begin
            walk_failed_next = 1'b1;
            error_code_next  = ST_POOL_FULL;
          end else begin
            alloc           = 1'b1;
            cursor_next     = nodes_used[NODE_W-1:0];
            nodes_used_next = nodes_used + 1'b1;
          end
        end else begin
          cursor_next = child_rdata;
        end
      end
    end
  end

  // Answer for an ending item
  always_comb begin
    res_found = 1'b0;
    if (!walk_failed_next) begin
      case (it_op)
        OP_SEARCH: res_found = flag_rdata[0];
        OP_PREFIX: res_found = (cursor_next != '0) || any_word_next;
        default:   res_found = 1'b0;
      endcase
    end
  end
  assign mark = cmd.finish && (it_op == OP_INSERT) && !walk_failed_next &&
                (cursor_next != '0);

  // Walk registers; return to the root when the word ends
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor      <= '0;
      nodes_used  <= (NODE_W + 1)'(1);
      walk_failed <= 1'b0;
      error_code  <= ST_OK;
      any_word    <= 1'b0;
      clr_addr    <= '0;
    end else begin
      nodes_used <= nodes_used_next;
      any_word   <= any_word_next;
      if (cmd.finish) begin
        cursor      <= '0;
        walk_failed <= 1'b0;
        error_code  <= ST_OK;
      end else begin
        cursor      <= cursor_next;
        walk_failed <= walk_failed_next;
        error_code  <= error_code_next;
      end
      if (cmd.clear) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Child table: zero sweep after reset, then node allocation
  assign child_we    = cmd.clear || alloc;
  assign child_waddr = cmd.clear ? clr_addr : it_slot;
  assign child_wdata = cmd.clear ? '0 : nodes_used[NODE_W-1:0];

  lte_ram #(
    .WIDTH (NODE_W),
    .DEPTH (DEPTH)
  ) u_child_ram (
    .clk   (clk),
    .we    (child_we),
    .waddr (child_waddr),
    .wdata (child_wdata),
    .raddr (in_slot),
    .rdata (child_rdata)
  );

  // Word-end flags: cleared by the same sweep, set by an ending insert
  assign flag_we    = cmd.clear ? (clr_addr < NODE_LIM) : mark;
  assign flag_waddr = cmd.clear ? clr_addr[NODE_W-1:0] : cursor_next;
  assign flag_wdata = cmd.clear ? 1'b0 : 1'b1;

  lte_ram #(
    .WIDTH (1),
    .DEPTH (NODE_COUNT)
  ) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .raddr (cursor_next),
    .rdata (flag_rdata)
  );

  // Output register with one skid slot behind it
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      pend_valid <= 1'b0;
    end else if (out_free) begin
      if (pend_valid) begin
        m_tvalid   <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        m_tvalid <= cmd.finish;
      end
    end else if (cmd.finish) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid) begin
        out_found  <= pend_found;
        out_status <= pend_status;
      end else begin
        out_found  <= res_found;
        out_status <= error_code_next;
      end
    end else if (cmd.finish) begin
      pend_found  <= res_found;
      pend_status <= error_code_next;
    end
  end

  assign m_tdata = {5'd0, out_status, out_found};

  // Status toward the controller
  assign stat.clr_last  = (clr_addr == CLR_LAST);
  assign stat.pend_full = pend_valid;
  assign stat.ends      = it_ends;
  assign stat.search    = (it_op == OP_SEARCH);

endmodule

// ===== design/lowercase_trie_engine.sv =====
// Trie of lowercase words in a pool of NODE_COUNT nodes, fed one character per beat.
// After reset the block zeroes its child table and word-end flags, one entry per
// cycle, NODE_COUNT*ALPHABET_SIZE entries (26624 at the default size), before
// s_tready first rises. Each character then takes a registered read of the child
// table and an update that may allocate a node and write it back. A search that
// ends the word adds a flag state, since the word-end flag of the final node is
// read after the last lookup. The answer is registered on the output. While one
// answer waits on the output the next word streams in; a second finished answer
// parks in a skid slot and holds s_tready low until the output drains.
module lowercase_trie_engine import lte_pkg::*; #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [1:0] operation, [9:2] letter, [15:10] zero
  input  logic                  s_tlast,   // last character of the word
  input  logic                  s_tuser,   // empty_word
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [0] found, [2:1] status, [7:3] zero
);

`include "assert_macros.svh"

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  lte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .stat     (stat),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  lte_dp #(
    .NODE_COUNT    (NODE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

  // An answer never lands while the skid slot is still occupied
  `ASSERT_NEVER(a_no_skid_overrun, clk, rst, cmd.finish && stat.pend_full, "answer lost: skid slot full")
  // An accepted beat is walked in the following cycle
  `ASSERT_NEXT(a_take_then_walk, clk, rst, cmd.take, cmd.walk, "accepted beat not walked")
  // After every answer, m_tvalid is high in the following cycle
  `ASSERT_NEXT(a_finish_shows, clk, rst, cmd.finish, m_tvalid, "answer not presented")
  // No beat is taken during the clearing pass
  `ASSERT_IMPLIES(a_clear_blocks, clk, rst, cmd.clear, !s_tready && !cmd.walk, "beat taken while clearing")

endmodule

// ===== tb/lte_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the lowercase trie engine: keeps its own copy of the trie, predicts
// the answer of every word from the input beats and checks each output beat.
// Depends on lte_pkg for the beat widths, the operation and status codes.
module lte_checker import lte_pkg::*; #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [1:0] operation, [9:2] letter, [15:10] zero
  input  logic                  s_tlast,   // last character of the word
  input  logic                  s_tuser,   // empty_word
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // [0] found, [2:1] status, [7:3] zero
  output int                    fail_count,
  output int                    pending,
  output int                    words_done,
  output int                    hits,
  output int                    full_seen,
  output int                    bad_seen
);

  typedef struct packed {
    logic    found;
    status_t status;
  } answer_t;

  // Shadow trie
  int      child_map [NODE_COUNT*ALPHABET_SIZE];
  bit      word_end  [NODE_COUNT];
  int      nodes_used;
  int      cursor;
  bit      walk_failed;
  status_t err;
  bit      any_word;

  answer_t expected_answers [$];
  int      errors;
  int      n_words, n_hits, n_full, n_bad;

  function automatic void reset_trie();
    foreach (child_map[i]) child_map[i] = 0;
    foreach (word_end[i]) word_end[i] = 1'b0;
    nodes_used  = 1;
    cursor      = 0;
    walk_failed = 1'b0;
    err         = ST_OK;
    any_word    = 1'b0;
  endfunction

  // Keep the first error of the word, stop the walk
  function automatic void flag_error(input status_t code);
    if (err == ST_OK) err = code;
    walk_failed = 1'b1;
  endfunction

  // Follow one character, allocating a node on insert when the child is missing
  function automatic void walk_char(input op_t op, input logic [7:0] ch);
    logic [7:0] idx;
    int         slot;
    int         nxt;
    if (walk_failed) return;
    idx = ch - FIRST_LETTER;
    if (ch < FIRST_LETTER || idx >= ALPHABET_SIZE) begin
      flag_error(ST_BAD_CHAR);
      return;
    end
    slot = cursor * ALPHABET_SIZE + idx;
    nxt  = child_map[slot];
    if (op == OP_INSERT) any_word = 1'b1;
    if (nxt == 0) begin
      if (op != OP_INSERT) begin
        walk_failed = 1'b1;
        return;
      end
      if (nodes_used >= NODE_COUNT) begin
        flag_error(ST_POOL_FULL);
        return;
      end
      nxt             = nodes_used;
      child_map[slot] = nxt;
      nodes_used++;
    end
    cursor = nxt;
  endfunction

  // Apply one input beat; returns 1 when the beat ends a word and yields an answer
  function automatic bit trie_step(input logic [1:0] raw_op, input logic [7:0] ch,
                                   input logic lst, input logic emp, output answer_t ans);
    op_t op;
    op         = raw_op[1] ? OP_PREFIX : op_t'(raw_op);
    ans.found  = 1'b0;
    ans.status = ST_OK;
    if (!emp) walk_char(op, ch);
    if (!emp && !lst) return 1'b0;
    if (op == OP_INSERT) begin
      if (!walk_failed && cursor != 0) word_end[cursor] = 1'b1;
    end else if (!walk_failed) begin
      if (op == OP_SEARCH) ans.found = word_end[cursor];
      else ans.found = (cursor != 0) || any_word;
    end
    ans.status  = err;
    cursor      = 0;
    walk_failed = 1'b0;
    err         = ST_OK;
    return 1'b1;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  initial begin
    errors  = 0;
    n_words = 0;
    n_hits  = 0;
    n_full  = 0;
    n_bad   = 0;
  end

  // Check answer beats first, then fold in the input beat of the same edge
  always @(posedge clk) begin : monitor
    answer_t got;
    answer_t want;
    answer_t nxt;
    if (rst) begin
      reset_trie();
      expected_answers.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.found  = m_tdata[0];
        got.status = status_t'(m_tdata[2:1]);
        if (expected_answers.size() == 0) begin
          report($sformatf("answer beat found=%b status=%0d with no word pending",
                           got.found, got.status));
        end else begin
          want = expected_answers.pop_front();
          n_words++;
          if (want.found) n_hits++;
          if (want.status == ST_POOL_FULL) n_full++;
          if (want.status == ST_BAD_CHAR) n_bad++;
          if (got.found !== want.found)
            report($sformatf("word %0d: found %b, want %b", n_words, got.found, want.found));
          if (got.status !== want.status)
            report($sformatf("word %0d: status %0d, want %0d", n_words, got.status,
                             want.status));
        end
      end
      if (s_tvalid && s_tready) begin
        if (trie_step(s_tdata[1:0], s_tdata[9:2], s_tlast, s_tuser, nxt))
          expected_answers.push_back(nxt);
      end
    end
    fail_count <= errors;
    pending    <= expected_answers.size();
    words_done <= n_words;
    hits       <= n_hits;
    full_seen  <= n_full;
    bad_seen   <= n_bad;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top of the lowercase trie engine testbench: clock, reset, word stimulus with random
// gaps and back-pressure, and the verdict. Depends on lte_pkg, the engine and lte_checker.
module tb;
  import lte_pkg::*;

  localparam int         STALL_LIMIT  = 100000;
  localparam int         RANDOM_BEATS = 600;
  localparam logic [1:0] OP_RAW_THREE = 2'd3;  // decodes as a prefix test
  localparam logic [7:0] CH_A         = FIRST_LETTER;
  localparam logic [7:0] CH_B         = FIRST_LETTER + 8'd1;
  localparam logic [7:0] CH_C         = FIRST_LETTER + 8'd2;
  localparam logic [7:0] CH_Q         = FIRST_LETTER + 8'd16;
  localparam logic [7:0] CH_Z         = FIRST_LETTER + 8'd25;
  localparam logic [7:0] CH_BELOW     = FIRST_LETTER - 8'd1;
  localparam logic [7:0] CH_ABOVE     = FIRST_LETTER + 8'd26;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // [1:0] operation, [9:2] letter, [15:10] zero
  logic                  s_tlast;   // last character of the word
  logic                  s_tuser;   // empty_word
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // [0] found, [2:1] status, [7:3] zero

  int fail_count, pending, words_done, hits, full_seen, bad_seen;
  int beats_sent;
  int quiet_cycles;
  bit src_gaps;
  bit sink_stalls;

  lowercase_trie_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  lte_checker answer_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .words_done (words_done),
    .hits       (hits),
    .full_seen  (full_seen),
    .bad_seen   (bad_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Drive one character beat and hold it until the engine takes it
  task automatic send_beat(input logic [1:0] op, input logic [7:0] ch,
                           input logic lst, input logic emp);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W-10){1'b0}}, ch, op};
    s_tlast  <= lst;
    s_tuser  <= emp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
  endtask

  // One random word: short, mostly from a few letters so words share prefixes
  task automatic random_word();
    int         len;
    int         pick;
    logic [1:0] op;
    logic [1:0] beat_op;
    logic [7:0] ch;
    bit         empty_end;
    len  = $urandom_range(0, 6);
    pick = $urandom_range(0, 9);
    if (pick < 4) op = OP_INSERT;
    else if (pick < 7) op = OP_SEARCH;
    else if (pick < 9) op = OP_PREFIX;
    else op = OP_RAW_THREE;
    if (len == 0) begin
      send_beat(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end else begin
      empty_end = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < len; i++) begin
        beat_op = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : op;
        pick    = $urandom_range(0, 29);
        if (pick == 0) ch = 8'($urandom_range(0, 255));
        else if (pick < 8) ch = FIRST_LETTER + 8'($urandom_range(0, 25));
        else ch = FIRST_LETTER + 8'($urandom_range(0, 3));
        if (i == len - 1 && !empty_end) send_beat(op, ch, 1'b1, 1'b0);
        else send_beat(beat_op, ch, 1'b0, 1'b0);
      end
      if (empty_end)
        send_beat(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  // Randomly withhold tready in short bursts
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_stalls && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog: count cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("lowercase_trie_engine test failed");
    $finish;
  end

  initial begin
    int mark;
    rst          <= 1'b1;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    s_tlast      <= 1'b0;
    s_tuser      <= 1'b0;
    quiet_cycles <= 0;
    beats_sent   = 0;
    src_gaps     = 1'b1;
    sink_stalls  = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty words on an empty trie; last is ignored on an empty beat
    send_beat(OP_SEARCH, 8'hFF, 1'b0, 1'b1);
    send_beat(OP_PREFIX, 8'h00, 1'b1, 1'b1);
    send_beat(OP_INSERT, CH_A, 1'b1, 1'b1);
    send_beat(OP_PREFIX, CH_Z, 1'b1, 1'b1);
    // Store "az", then probe it
    send_beat(OP_INSERT, CH_A, 1'b0, 1'b0);
    send_beat(OP_INSERT, CH_Z, 1'b1, 1'b0);
    send_beat(OP_SEARCH, CH_A, 1'b1, 1'b0);
    send_beat(OP_PREFIX, CH_A, 1'b1, 1'b0);
    send_beat(OP_SEARCH, CH_A, 1'b0, 1'b0);
    send_beat(OP_SEARCH, CH_Z, 1'b1, 1'b0);
    send_beat(OP_PREFIX, 8'h55, 1'b0, 1'b1);
    send_beat(OP_RAW_THREE, CH_A, 1'b0, 1'b0);
    send_beat(OP_RAW_THREE, CH_Z, 1'b1, 1'b0);
    // Characters just outside the alphabet and at the byte extremes
    send_beat(OP_INSERT, CH_A, 1'b0, 1'b0);
    send_beat(OP_INSERT, CH_BELOW, 1'b1, 1'b0);
    send_beat(OP_INSERT, CH_ABOVE, 1'b0, 1'b0);
    send_beat(OP_INSERT, CH_B, 1'b1, 1'b0);
    send_beat(OP_SEARCH, 8'h00, 1'b1, 1'b0);
    send_beat(OP_PREFIX, 8'hFF, 1'b1, 1'b0);
    // Mixed operations: a failed search step blocks the insert that follows
    send_beat(OP_SEARCH, CH_B, 1'b0, 1'b0);
    send_beat(OP_INSERT, CH_C, 1'b1, 1'b0);
    // Word closed by an empty beat
    send_beat(OP_SEARCH, CH_A, 1'b0, 1'b0);
    send_beat(OP_SEARCH, CH_Z, 1'b0, 1'b0);
    send_beat(OP_SEARCH, 8'hA5, 1'b0, 1'b1);

    // Random words with gaps and back-pressure switched on and off per word
    mark = beats_sent;
    while (beats_sent - mark < RANDOM_BEATS) begin
      src_gaps    = ($urandom_range(0, 2) != 0);
      sink_stalls = ($urandom_range(0, 2) != 0);
      random_word();
    end

    // Final stretch with no gaps and no back-pressure
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    send_beat(OP_INSERT, 8'd200, 1'b1, 1'b0);
    send_beat(OP_PREFIX, CH_Q, 1'b0, 1'b0);
    send_beat(OP_PREFIX, CH_Q, 1'b1, 1'b0);
    mark = beats_sent;
    while (beats_sent - mark < 120) random_word();

    // Drain
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d beats and %0d words: %0d found, %0d pool full, %0d bad character",
             beats_sent, words_done, hits, full_seen, bad_seen);
    $display("Mismatches: %0d", fail_count);
    if (fail_count == 0) begin
      $display("lowercase_trie_engine test passed");
    end else begin
      $display("lowercase_trie_engine test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/lte_pkg.sv
design/lte_ram.sv
design/lte_ctrl.sv
design/lte_dp.sv
design/lowercase_trie_engine.sv
tb/lte_checker.sv
tb/tb.sv
